FILE: hw/rtl/packet_dedup_fifo_set_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet duplicate filter
// Shorthand for clocked checks, sampled on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEDUP_FIFO_SET_MACROS_SVH
`define PACKET_DEDUP_FIFO_SET_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define PDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define PDF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pdf_pkg.sv
// ----------------------------------------------------------------------------
// Packet duplicate filter package
// Shared types and constants for the filter and its key cells.
// ----------------------------------------------------------------------------
package pdf_pkg;

  localparam int unsigned IdentW       = 16;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned KeyW         = IdentW + AddrW;
  localparam int unsigned CfgW         = 7;
  localparam int unsigned StoreDepthDefault = 64;
  localparam logic [CfgW-1:0] LimitReset = 7'd64;

  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic [IdentW-1:0] ip_ident;
    logic [AddrW-1:0]  source_address;
  } pdf_req_t;

  typedef struct packed {
    logic verdict;
    logic evicted;
  } pdf_res_t;

  // Control broadcast to every cell of the key chain.
  typedef struct packed {
    logic cmp_en;    // register a fresh match flag
    logic shift_en;  // advance keys one cell down the chain
  } pdf_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DECIDE = 2'b10
  } pdf_state_e;

endpackage

FILE: hw/rtl/pdf_cell.sv
// ----------------------------------------------------------------------------
// Key cell
// Holds one stored key, passes it to the next cell on a shift and flags
// a match against the broadcast key.
// ----------------------------------------------------------------------------
module pdf_cell import pdf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pdf_cell_ctrl_t ctrl_i,
  input  logic           valid_i,
  input  key_t           cmp_key_i,
  input  key_t           key_i,
  output key_t           key_o,
  output logic           hit_o
);

  key_t key_q;
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      key_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      hit_q <= valid_i && (key_q == cmp_key_i);
    end
  end

  assign key_o = key_q;
  assign hit_o = hit_q;

endmodule

FILE: hw/rtl/packet_dedup_fifo_set.sv
// ----------------------------------------------------------------------------
// Packet duplicate filter with first-in-first-out eviction
// Drops packets whose identification and source address were seen recently.
// ----------------------------------------------------------------------------
// Usage: raise start with a header on req_i; the item transfers at a clock
// edge where busy is low. For each item, in the transfer
// cycle each key cell compares its key against the new one and registers a
// match flag; in the next cycle (busy high) the flags are OR-ed, the
// verdict is decided, and the result appears on res_o with done_o high for
// exactly one cycle. The receiver cannot stall, so it must take the result
// in that cycle. A new item can transfer in the cycle right after the
// result, but not while busy is high. An identification of zero is
// forwarded and stores nothing. cfg_we_i writes the capacity limit (reset
// 64; zero acts as one, values above STORE_DEPTH as STORE_DEPTH); write it
// only while no item is in flight.
//
// Keys live in a chain of STORE_DEPTH cells. A new key enters cell 0 and
// every key moves one cell down, so the oldest key sits at cell count-1.
// Cells at index count and above hold nothing valid. Evicting the oldest key
// on insert leaves the count unchanged, which pushes it out of the valid
// range. Reset empties the store at once through the count.
// ----------------------------------------------------------------------------
module packet_dedup_fifo_set import pdf_pkg::*; #(
  parameter int unsigned STORE_DEPTH = StoreDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pdf_req_t        req_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic            done_o,
  output pdf_res_t        res_o
);

  `include "packet_dedup_fifo_set_macros.svh"

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LimW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [LimW-1:0] DepthLim = LimW'(STORE_DEPTH);

  pdf_state_e      state_q, state_d;
  logic [CfgW-1:0] limit_q;
  logic [CntW-1:0] count_q, count_d;
  key_t            key_q;
  logic            tracked_q;
  logic            accept;

  pdf_cell_ctrl_t  cell_ctrl;
  key_t            chain   [STORE_DEPTH+1];
  logic [STORE_DEPTH-1:0] cell_valid;
  logic [STORE_DEPTH-1:0] cell_hit;

  logic [LimW-1:0] limit_ext;
  logic [LimW-1:0] eff_limit;
  logic [LimW-1:0] count_ext;
  logic            hit;
  logic            insert;
  logic            evict;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_DECIDE);

  // Register the limit; no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Clamp the limit into one to STORE_DEPTH.
  always_comb begin
    limit_ext = LimW'(limit_q);
    if (limit_ext == '0) begin
      eff_limit = LimW'(1);
    end else if (limit_ext > DepthLim) begin
      eff_limit = DepthLim;
    end else begin
      eff_limit = limit_ext;
    end
  end

  // Hold the key of the item under decision.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q     <= {req_i.ip_ident, req_i.source_address};
      tracked_q <= (req_i.ip_ident != '0);
    end
  end

  // Compare in the transfer cycle; shift on an insert in the decide cycle.
  assign cell_ctrl.cmp_en   = accept;
  assign cell_ctrl.shift_en = insert;
  assign chain[0]           = key_q;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (CntW'(i) < count_q);

    pdf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .valid_i   (cell_valid[i]),
      .cmp_key_i ({req_i.ip_ident, req_i.source_address}),
      .key_i     (chain[i]),
      .key_o     (chain[i+1]),
      .hit_o     (cell_hit[i])
    );
  end

  // Decide: a miss on a tracked key inserts, evicting the oldest at the limit.
  assign hit       = |cell_hit;
  assign count_ext = LimW'(count_q);
  assign insert    = busy && tracked_q && !hit;
  assign evict     = insert && (count_ext >= eff_limit) && (count_q != '0);

  always_comb begin
    count_d = count_q;
    if (insert && !evict) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Present the result for the one decide cycle.
  assign done_o        = busy;
  assign res_o.verdict = busy && tracked_q && hit;
  assign res_o.evicted = evict;

  `PDF_ASSERT_NEXT(a_result_follows, accept, done_o, "no result after transfer")
  `PDF_ASSERT_SAME(a_drop_no_evict, done_o && res_o.verdict, !res_o.evicted,
                   "drop verdict with eviction")
  `PDF_ASSERT_NEXT(a_evict_keeps_count, done_o && res_o.evicted,
                   count_q == $past(count_q), "count changed on eviction")
  `PDF_ASSERT_NEXT(a_one_cycle_result, done_o, !done_o, "result held over two cycles")

endmodule

FILE: bench/tb_packet_dedup_fifo_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the packet duplicate filter
// Sends directed and random packet headers and checks every verdict and
// eviction flag against a queue-based predictor of the key store, or against the typed-in result of a pinned plan row.
// ----------------------------------------------------------------------------
module tb_packet_dedup_fifo_set;
  import pdf_pkg::*;

  localparam int unsigned WatchdogLimit = 500;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned PhaseItems    = 160;
  localparam int unsigned PoolSize      = 96;
  localparam int unsigned PlanLen       = 23;

  // Directed plan: either a header transfer or a capacity limit write.
  typedef enum logic {
    ROW_ITEM,
    ROW_LIMIT
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [IdentW-1:0] ident;
    logic [AddrW-1:0]  addr;
    logic [CfgW-1:0]   limit;
    logic              pinned;  // typed-in result below replaces the prediction
    pdf_res_t          res;
  } plan_row_t;

  // Walk: fill a few keys at the reset limit, lower the limit below the count,
  // then try the zero and oversized limit values.
  plan_row_t plan [PlanLen] = '{
    '{ROW_ITEM,  16'h0000, 32'h0000_0000, 7'd0,   1'b1, 2'b00},  // untracked
    '{ROW_ITEM,  16'h0000, 32'hFFFF_FFFF, 7'd0,   1'b1, 2'b00},  // untracked
    '{ROW_ITEM,  16'hFFFF, 32'hFFFF_FFFF, 7'd0,   1'b1, 2'b00},  // first sight
    '{ROW_ITEM,  16'hFFFF, 32'hFFFF_FFFF, 7'd0,   1'b1, 2'b10},  // duplicate
    '{ROW_ITEM,  16'h0000, 32'hFFFF_FFFF, 7'd0,   1'b1, 2'b00},  // untracked again
    '{ROW_ITEM,  16'h0001, 32'h0000_0000, 7'd0,   1'b1, 2'b00},
    '{ROW_ITEM,  16'h0001, 32'h0000_0000, 7'd0,   1'b1, 2'b10},
    '{ROW_ITEM,  16'h0001, 32'h0000_0001, 7'd0,   1'b0, 2'b00},
    '{ROW_ITEM,  16'h8000, 32'h8000_0000, 7'd0,   1'b0, 2'b00},
    '{ROW_ITEM,  16'h7FFF, 32'h7FFF_FFFF, 7'd0,   1'b0, 2'b00},
    '{ROW_ITEM,  16'h0002, 32'h0000_0000, 7'd0,   1'b0, 2'b00},
    '{ROW_ITEM,  16'h0001, 32'h0000_0001, 7'd0,   1'b0, 2'b00},
    '{ROW_LIMIT, 16'h0000, 32'h0000_0000, 7'd1,   1'b0, 2'b00},  // below count
    '{ROW_ITEM,  16'h1234, 32'h5678_ABCD, 7'd0,   1'b1, 2'b01},  // miss evicts
    '{ROW_ITEM,  16'hFFFF, 32'hFFFF_FFFF, 7'd0,   1'b0, 2'b00},
    '{ROW_ITEM,  16'h1234, 32'h5678_ABCD, 7'd0,   1'b1, 2'b10},
    '{ROW_ITEM,  16'h0000, 32'h0000_0000, 7'd0,   1'b1, 2'b00},
    '{ROW_LIMIT, 16'h0000, 32'h0000_0000, 7'd0,   1'b0, 2'b00},  // acts as one
    '{ROW_ITEM,  16'h0001, 32'h0000_0000, 7'd0,   1'b0, 2'b00},
    '{ROW_LIMIT, 16'h0000, 32'h0000_0000, 7'd127, 1'b0, 2'b00},  // clamps to depth
    '{ROW_ITEM,  16'h4321, 32'h0000_FFFF, 7'd0,   1'b0, 2'b00},
    '{ROW_ITEM,  16'h4321, 32'h0000_FFFF, 7'd0,   1'b1, 2'b10},
    '{ROW_LIMIT, 16'h0000, 32'h0000_0000, 7'd64,  1'b0, 2'b00}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  pdf_req_t        req_i;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic            done_o;
  pdf_res_t        res_o;

  // Typed-in result that travels with the header in flight.
  logic            pin_valid;
  pdf_res_t        pin_res;

  // Predictor state: keys oldest first, and the shadow of the limit register.
  key_t            held_keys[$];
  logic [CfgW-1:0] limit_shadow = LimitReset;

  pdf_res_t        pending_verdicts[$];
  int unsigned     bad_results = 0;
  int unsigned     quiet_cycles = 0;

  packet_dedup_fifo_set dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Look a nonzero-identification key up among the held keys; on a miss drop the oldest
  // key when the store is at its limit, then append the new one.
  function automatic pdf_res_t filter_verdict(input pdf_req_t hdr);
    key_t        key;
    int unsigned cap;
    pdf_res_t    r;
    key = {hdr.ip_ident, hdr.source_address};
    r   = '0;
    if (hdr.ip_ident != '0) begin
      foreach (held_keys[i]) begin
        if (held_keys[i] == key) r.verdict = 1'b1;
      end
      if (!r.verdict) begin
        cap = (limit_shadow == '0) ? 1 : int'(limit_shadow);
        if (cap > StoreDepthDefault) cap = StoreDepthDefault;
        if (held_keys.size() >= cap) begin
          held_keys.delete(0);
          r.evicted = 1'b1;
        end
        held_keys.push_back(key);
      end
    end
    return r;
  endfunction

  // Everything is sampled at the rising edge, so both the driven inputs and
  // the block's outputs are seen with their values from before the edge.
  always @(posedge clk_i) begin : track_block
    pdf_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) limit_shadow = cfg_wdata_i;

      // Check the result first: it can never belong to a header that
      // transfers at this same edge.
      if (done_o) begin
        if (pending_verdicts.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("[%0t] result with no header in flight: verdict %0b evicted %0b",
                     $realtime, res_o.verdict, res_o.evicted);
        end else begin
          want = pending_verdicts.pop_front();
          if (res_o.verdict !== want.verdict || res_o.evicted !== want.evicted) begin
            bad_results++;
            if (bad_results <= 10)
              $display("[%0t] mismatch: verdict exp %0b got %0b, evicted exp %0b got %0b",
                       $realtime, want.verdict, res_o.verdict, want.evicted,
                       res_o.evicted);
          end
        end
      end

      if (start && !busy) begin
        want = filter_verdict(req_i);
        if (pin_valid) want = pin_res;
        pending_verdicts.push_back(want);
      end

      // Watchdog: count edges with no transfer in either direction.
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog expired", $realtime);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Present one header and hold it until the block takes it.
  task automatic send_header(input pdf_req_t hdr, input logic pinned, input pdf_res_t res);
    start     <= 1'b1;
    req_i     <= hdr;
    pin_valid <= pinned;
    pin_res   <= res;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender gaps: a pause after about 22 headers in a hundred, none in a quiet stretch.
  task automatic pace_sender(input bit quiet);
    if (!quiet && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Hold off new headers until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  task automatic write_limit(input logic [CfgW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] phase_limits [7];
    pdf_req_t        key_pool [PoolSize];
    pdf_req_t        hdr;
    int unsigned     pool_span;
    int unsigned     pick;

    phase_limits = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd2, 7'd63};

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    pin_valid   <= 1'b0;
    pin_res     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through the plan table.
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_LIMIT) begin
        write_limit(plan[r].limit);
      end else begin
        hdr.ip_ident       = plan[r].ident;
        hdr.source_address = plan[r].addr;
        send_header(hdr, plan[r].pinned, plan[r].res);
        pace_sender(1'b0);
      end
    end

    // Random phases: each picks a limit and a pool of keys so that hits,
    // misses and evictions all occur; a few headers are untracked or fresh.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      write_limit(phase < 7 ? phase_limits[phase] : CfgW'($urandom_range(0, 127)));
      pool_span = $urandom_range(1, PoolSize);
      foreach (key_pool[k]) begin
        key_pool[k].ip_ident       = IdentW'($urandom_range(1, 65535));
        key_pool[k].source_address = $urandom;
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          hdr.ip_ident       = '0;
          hdr.source_address = $urandom;
        end else if (pick < 15) begin
          hdr.ip_ident       = IdentW'($urandom_range(0, 65535));
          hdr.source_address = $urandom;
        end else begin
          hdr = key_pool[$urandom_range(0, pool_span - 1)];
        end
        send_header(hdr, 1'b0, '0);
        // Drain mid-phase now and then, and always once in the first phase.
        if ((phase == 0 && n == PhaseItems / 2) || $urandom_range(0, 199) == 0)
          drain_results();
        else
          pace_sender(phase == 2);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (bad_results == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
